/* hdl/fap_pkg.sv */
// Shared types and constants for the first-fit partition allocator.
// No dependencies; every other file imports this package.
package fap_pkg;

  localparam int OP_W  = 2;
  localparam int IDX_W = 3;
  localparam int AMT_W = 16;
  localparam int SUM_W = 19;
  localparam int CFG_W = 4;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_REQ   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [CFG_W-1:0] PARTS_IN_USE_RST = 4'd8;

  // search token walking the cell row
  typedef struct packed {
    logic             vld;
    logic             found;
    logic [AMT_W-1:0] amt;
    logic [SUM_W-1:0] acc;
  } tok_t;

  // broadcast control to every cell
  typedef struct packed {
    logic             load;
    logic             clear;
    logic [IDX_W-1:0] idx;
  } ctl_t;

endpackage

/* hdl/fap_if.sv */
// Valid/ready channel interfaces for the allocator's request and result beats.
// Depends on fap_pkg.
interface fap_in_if;
  import fap_pkg::*;

  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  opcode;
  logic [IDX_W-1:0] part_index;
  logic [AMT_W-1:0] amount;

  modport source (output valid, opcode, part_index, amount, input ready);
  modport sink   (input valid, opcode, part_index, amount, output ready);
endinterface

interface fap_out_if #(parameter int PNUM_W = 4);
  import fap_pkg::*;

  logic              valid;
  logic              ready;
  logic              granted;
  logic [PNUM_W-1:0] part_number;
  logic [SUM_W-1:0]  base_address;
  logic [SUM_W-1:0]  used_total;

  modport source (output valid, granted, part_number, base_address, used_total, input ready);
  modport sink   (input valid, granted, part_number, base_address, used_total, output ready);
endinterface

/* hdl/fap_cell.sv */
// One partition cell: holds its size and taken flag, tests the passing token.
// Depends on fap_pkg.
module fap_cell #(
  parameter int IDX       = 0,
  parameter int SIZE_BITS = 16,
  parameter int PNUM_W    = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  fap_pkg::ctl_t         ctl,
  input  logic [SIZE_BITS-1:0]  load_size,
  input  logic                  in_use,
  input  fap_pkg::tok_t         tok_in,
  input  logic [PNUM_W-1:0]     pnum_in,
  output fap_pkg::tok_t         tok_out,
  output logic [PNUM_W-1:0]     pnum_out
);
  import fap_pkg::*;

  localparam int CW = (SIZE_BITS > AMT_W) ? SIZE_BITS : AMT_W;
  localparam int AW = ((SIZE_BITS > SUM_W) ? SIZE_BITS : SUM_W) + 1;

  logic [SIZE_BITS-1:0] size_r;
  logic                 taken_r, taken_nxt;
  tok_t                 tok_r, tok_nxt;
  logic [PNUM_W-1:0]    pnum_r, pnum_nxt;
  logic                 fit;
  logic [AW-1:0]        sum;

  assign fit = tok_in.vld && !tok_in.found && in_use && !taken_r &&
               (CW'(size_r) >= CW'(tok_in.amt));
  assign sum = AW'(tok_in.acc) + AW'(size_r);

  always_comb begin
    tok_nxt       = tok_in;
    tok_nxt.found = tok_in.found | fit;
    pnum_nxt      = fit ? PNUM_W'(IDX + 1) : pnum_in;
    if (!tok_in.found && !fit) begin
      tok_nxt.acc = (sum > AW'(SUM_MAX)) ? SUM_MAX : sum[SUM_W-1:0];
    end
    taken_nxt = ctl.clear ? 1'b0 : (taken_r | fit);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= '0;
      taken_r <= 1'b0;
      tok_r   <= '0;
    end else begin
      taken_r <= taken_nxt;
      tok_r   <= tok_nxt;
      if (ctl.load && (32'(ctl.idx) == IDX)) begin
        size_r <= load_size;
      end
    end
  end

  always_ff @(posedge clk) begin
    pnum_r <= pnum_nxt;
  end

  assign tok_out  = tok_r;
  assign pnum_out = pnum_r;

endmodule

/* hdl/first_fit_partition_allocator.sv */
// Top level: first-fit fixed-partition allocator built as a row of fap_cell.
// Depends on fap_pkg, fap_in_if, fap_out_if and fap_cell.
//
//   channel  dir  beat contents
//   in_if    in   opcode, part_index, amount
//   out_if   out  granted, part_number, base_address, used_total
//   cfg_*    in   parts_in_use (write only)
//
// A request walks the cell row one cell per clock, its result registered after
// the last cell; one request in flight at once. Load and clear beats give their
// result on the next cycle. A waiting result stalls further input. Synchronous
// active-low reset frees all partitions, zeroes sizes and the used total.
module first_fit_partition_allocator #(
  parameter int PARTS     = 8,
  parameter int SIZE_BITS = 16,
  parameter int PNUM_W    = 4
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     cfg_we,
  input  logic [fap_pkg::CFG_W-1:0] cfg_wdata,
  fap_in_if.sink                   in_if,
  fap_out_if.source                out_if
);
  import fap_pkg::*;

  logic [CFG_W-1:0]     piu_r;
  logic                 busy_r, busy_nxt;
  logic                 out_vld_r, out_vld_nxt;
  logic                 granted_r, granted_nxt;
  logic [PNUM_W-1:0]    pnum_r, pnum_nxt;
  logic [SUM_W-1:0]     base_r, base_nxt;
  logic [SUM_W-1:0]     used_r, used_nxt;
  logic [SUM_W-1:0]     used_sum_r, used_sum_nxt;
  logic [SUM_W:0]       used_add;
  logic                 accept, tail;
  ctl_t                 ctl;
  logic [SIZE_BITS-1:0] load_size;
  logic [PARTS-1:0]     in_use;
  logic [PARTS-1:0]     tok_vld;

  tok_t              tok  [0:PARTS];
  logic [PNUM_W-1:0] pnum [0:PARTS];

  assign in_if.ready = !busy_r && (!out_vld_r || out_if.ready);
  assign accept      = in_if.valid && in_if.ready;

  assign ctl.load  = accept && (in_if.opcode == OP_LOAD);
  assign ctl.clear = accept && (in_if.opcode == OP_CLEAR);
  assign ctl.idx   = in_if.part_index;
  assign load_size = SIZE_BITS'(in_if.amount);

  assign tok[0].vld   = accept && (in_if.opcode == OP_REQ);
  assign tok[0].found = 1'b0;
  assign tok[0].amt   = in_if.amount;
  assign tok[0].acc   = '0;
  assign pnum[0]      = '0;

  for (genvar i = 0; i < PARTS; i++) begin : g_cell
    assign in_use[i]  = 32'(piu_r) > i;
    assign tok_vld[i] = tok[i+1].vld;
    fap_cell #(
      .IDX       (i),
      .SIZE_BITS (SIZE_BITS),
      .PNUM_W    (PNUM_W)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .load_size (load_size),
      .in_use    (in_use[i]),
      .tok_in    (tok[i]),
      .pnum_in   (pnum[i]),
      .tok_out   (tok[i+1]),
      .pnum_out  (pnum[i+1])
    );
  end

  assign tail     = tok[PARTS].vld;
  assign used_add = (SUM_W+1)'(used_sum_r) + (SUM_W+1)'(tok[PARTS].amt);

  always_comb begin
    busy_nxt     = busy_r;
    out_vld_nxt  = out_vld_r && !out_if.ready;
    granted_nxt  = granted_r;
    pnum_nxt     = pnum_r;
    base_nxt     = base_r;
    used_nxt     = used_r;
    used_sum_nxt = used_sum_r;
    if (tail) begin
      busy_nxt    = 1'b0;
      out_vld_nxt = 1'b1;
      granted_nxt = tok[PARTS].found;
      pnum_nxt    = pnum[PARTS];
      base_nxt    = tok[PARTS].found ? tok[PARTS].acc : '0;
      if (tok[PARTS].found) begin
        used_sum_nxt = used_add[SUM_W] ? SUM_MAX : used_add[SUM_W-1:0];
      end
      used_nxt = used_sum_nxt;
    end else if (accept) begin
      if (in_if.opcode == OP_REQ) begin
        busy_nxt = 1'b1;
      end else begin
        out_vld_nxt = 1'b1;
        granted_nxt = 1'b0;
        pnum_nxt    = '0;
        base_nxt    = '0;
        if (in_if.opcode == OP_CLEAR) begin
          used_sum_nxt = '0;
        end
        used_nxt = used_sum_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      piu_r      <= PARTS_IN_USE_RST;
      busy_r     <= 1'b0;
      out_vld_r  <= 1'b0;
      used_sum_r <= '0;
    end else begin
      if (cfg_we) begin
        piu_r <= cfg_wdata;
      end
      busy_r     <= busy_nxt;
      out_vld_r  <= out_vld_nxt;
      used_sum_r <= used_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    granted_r <= granted_nxt;
    pnum_r    <= pnum_nxt;
    base_r    <= base_nxt;
    used_r    <= used_nxt;
  end

  assign out_if.valid        = out_vld_r;
  assign out_if.granted      = granted_r;
  assign out_if.part_number  = pnum_r;
  assign out_if.base_address = base_r;
  assign out_if.used_total   = used_r;

  a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_vld))
    else $error("more than one search token in the cell row");

  a_token_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (tok_vld != '0) |-> busy_r)
    else $error("search token in flight while not busy");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !in_if.ready)
    else $error("input accepted during a search");

  a_grant_pnum: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (granted_r == (pnum_r != '0)))
    else $error("granted and part number disagree");

  a_nogrant_base: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !granted_r) |-> (base_r == '0))
    else $error("base address set without a grant");

endmodule
